// File: rtl/mrt_pkg.sv
package mrt_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int IDX_CW     = IDX_W + 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int RL_W       = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INIT = 2'd0,
    OP_RECV = 2'd1,
    OP_EXT  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_SPLIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             chk;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [DATA_W-1:0] hit_b;
    logic [DATA_W-1:0] hit_f;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              best;
    logic [IDX_W-1:0]  best_idx;
  } scan_res_t;

endpackage

// File: rtl/mrt_ram.sv
module mrt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/mrt_scan.sv
module mrt_scan
  import mrt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] seg_start_i,
  input  logic [DATA_W-1:0] seg_end_i,
  input  logic [DATA_W-1:0] rd_begin_i,
  input  logic [DATA_W-1:0] rd_finish_i,
  input  logic              entry_valid_i,
  output scan_res_t         res_o
);

  logic              hit_q, hit_d;
  logic              free_q, free_d;
  logic              best_q, best_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [DATA_W-1:0] hit_b_q, hit_b_d;
  logic [DATA_W-1:0] hit_f_q, hit_f_d;
  logic [DATA_W-1:0] best_b_q, best_b_d;
  logic              holds;

  assign holds = (seg_start_i >= rd_begin_i) && (seg_start_i <= rd_finish_i) &&
                 (seg_end_i >= rd_begin_i) && (seg_end_i <= rd_finish_i);

  always_comb begin
    hit_d      = hit_q;
    free_d     = free_q;
    best_d     = best_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    best_idx_d = best_idx_q;
    hit_b_d    = hit_b_q;
    hit_f_d    = hit_f_q;
    best_b_d   = best_b_q;
    if (ctl_i.clear) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      best_d = 1'b0;
    end else if (ctl_i.chk) begin
      if (!entry_valid_i) begin
        if (!free_q) begin
          free_d     = 1'b1;
          free_idx_d = ctl_i.idx;
        end
      end else begin
        if (!hit_q && holds) begin
          hit_d     = 1'b1;
          hit_idx_d = ctl_i.idx;
          hit_b_d   = rd_begin_i;
          hit_f_d   = rd_finish_i;
        end
        // strict compare keeps the lowest slot on a tie
        if (!best_q || (rd_begin_i > best_b_q)) begin
          best_d     = 1'b1;
          best_idx_d = ctl_i.idx;
          best_b_d   = rd_begin_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      best_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    best_idx_q <= best_idx_d;
    hit_b_q    <= hit_b_d;
    hit_f_q    <= hit_f_d;
    best_b_q   <= best_b_d;
  end

  assign res_o.hit      = hit_q;
  assign res_o.hit_idx  = hit_idx_q;
  assign res_o.hit_b    = hit_b_q;
  assign res_o.hit_f    = hit_f_q;
  assign res_o.free     = free_q;
  assign res_o.free_idx = free_idx_q;
  assign res_o.best     = best_q;
  assign res_o.best_idx = best_idx_q;

endmodule

// File: rtl/missing_range_tracker.sv
// init and the unused opcode go from idle straight to the done state;
// receive and extend scan every slot before the update, and a split also passes through the split state
// throughput: one transaction at a time, bound by the serial scan over the range
// memories, which share one read address, one slot per cycle
// reset: valid bits, range count, sequencer and output valid cleared at once;
// range bounds memory is not cleared and is only used for valid slots
module missing_range_tracker
  import mrt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [DATA_W-1:0] seg_start_i,
  input  logic [DATA_W-1:0] seg_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [RL_W-1:0]   ranges_left_o,
  output logic              complete_o
);

  localparam logic [IDX_CW-1:0] IDX_END = IDX_CW'(MAX_RANGES);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_RANGES - 1);

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [DATA_W-1:0]       s_q, s_d;
  logic [DATA_W-1:0]       e_q, e_d;
  logic [IDX_CW-1:0]       idx_q, idx_d;
  logic                    chk_q, chk_d;
  logic [IDX_W-1:0]        chk_idx_q;
  logic [MAX_RANGES-1:0]   valid_q, valid_d;
  logic [CNT_W-1:0]        count_q, count_d;
  status_e                 status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q;
  logic [RL_W-1:0]         out_left_q;
  logic                    out_cmpl_q;
  logic                    out_load;
  logic                    in_accept;
  logic                    scan_clear;

  logic                    beg_we, fin_we;
  logic [IDX_W-1:0]        beg_addr, fin_addr;
  logic [DATA_W-1:0]       beg_wdata, fin_wdata;
  logic [DATA_W-1:0]       rd_begin, rd_finish;

  scan_ctl_t               scan_ctl;
  scan_res_t               scan_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  mrt_ram #(.DEPTH(MAX_RANGES), .WIDTH(DATA_W)) u_begin_ram (
    .clk_i   (clk_i),
    .we_i    (beg_we),
    .waddr_i (beg_addr),
    .wdata_i (beg_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_begin)
  );

  mrt_ram #(.DEPTH(MAX_RANGES), .WIDTH(DATA_W)) u_finish_ram (
    .clk_i   (clk_i),
    .we_i    (fin_we),
    .waddr_i (fin_addr),
    .wdata_i (fin_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_finish)
  );

  assign scan_ctl.clear = scan_clear;
  assign scan_ctl.chk   = chk_q;
  assign scan_ctl.idx   = chk_idx_q;

  mrt_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .seg_start_i   (s_q),
    .seg_end_i     (e_q),
    .rd_begin_i    (rd_begin),
    .rd_finish_i   (rd_finish),
    .entry_valid_i (valid_q[chk_idx_q]),
    .res_o         (scan_res)
  );

  assign chk_d = (state_q == S_SCAN) && (idx_q != IDX_END);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    s_d        = s_q;
    e_d        = e_q;
    idx_d      = idx_q;
    valid_d    = valid_q;
    count_d    = count_q;
    status_d   = status_q;
    out_load   = 1'b0;
    scan_clear = 1'b0;
    beg_we     = 1'b0;
    beg_addr   = '0;
    beg_wdata  = '0;
    fin_we     = 1'b0;
    fin_addr   = '0;
    fin_wdata  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d = op_e'(opcode_i);
          s_d  = seg_start_i;
          e_d  = seg_end_i;
          case (op_e'(opcode_i))
            OP_INIT: begin
              valid_d    = '0;
              valid_d[0] = 1'b1;
              count_d    = CNT_W'(1);
              beg_we     = 1'b1;
              fin_we     = 1'b1;
              fin_wdata  = seg_end_i;
              status_d   = ST_OK;
              state_d    = S_DONE;
            end
            OP_RECV, OP_EXT: begin
              scan_clear = 1'b1;
              idx_d      = '0;
              state_d    = S_SCAN;
            end
            default: begin
              status_d = ST_OK;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q == IDX_END) begin
          state_d = S_UPD;
        end else begin
          idx_d = idx_q + IDX_CW'(1);
        end
      end
      S_UPD: begin
        state_d  = S_DONE;
        status_d = ST_OK;
        if (op_q == OP_EXT) begin
          if (!scan_res.best) begin
            status_d = ST_EMPTY;
          end else begin
            fin_we    = 1'b1;
            fin_addr  = scan_res.best_idx;
            fin_wdata = e_q;
          end
        end else if (!scan_res.hit) begin
          status_d = ST_NOMATCH;
        end else if ((s_q == scan_res.hit_b) && (e_q == scan_res.hit_f)) begin
          valid_d[scan_res.hit_idx] = 1'b0;
          count_d                   = count_q - CNT_W'(1);
        end else if ((s_q == scan_res.hit_b) && (s_q < scan_res.hit_f)) begin
          beg_we    = 1'b1;
          beg_addr  = scan_res.hit_idx;
          beg_wdata = e_q;
        end else if ((e_q == scan_res.hit_f) && (s_q > scan_res.hit_b)) begin
          fin_we    = 1'b1;
          fin_addr  = scan_res.hit_idx;
          fin_wdata = s_q;
        end else if (!scan_res.free) begin
          status_d = ST_FULL;
        end else begin
          // split: upper part goes to the lowest free slot
          beg_we                     = 1'b1;
          beg_addr                   = scan_res.free_idx;
          beg_wdata                  = e_q;
          fin_we                     = 1'b1;
          fin_addr                   = scan_res.free_idx;
          fin_wdata                  = scan_res.hit_f;
          valid_d[scan_res.free_idx] = 1'b1;
          count_d                    = count_q + CNT_W'(1);
          state_d                    = S_SPLIT;
        end
      end
      S_SPLIT: begin
        fin_we    = 1'b1;
        fin_addr  = scan_res.hit_idx;
        fin_wdata = s_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      chk_q       <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    s_q       <= s_d;
    e_q       <= e_d;
    status_q  <= status_d;
    chk_idx_q <= idx_q[IDX_W-1:0];
    if (out_load) begin
      out_status_q <= status_q;
      out_left_q   <= RL_W'(count_q);
      out_cmpl_q   <= (count_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign ranges_left_o = out_left_q;
  assign complete_o    = out_cmpl_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("range count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RANGES))
    else $error("range count above table size");

  a_scan_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ($past(chk_q) && ($past(chk_idx_q) == IDX_LAST)))
    else $error("update started before the last slot was checked");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mrt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TOTAL_ITEMS   = 1650;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    SEG_EXACT,
    SEG_TRIM_LO,
    SEG_TRIM_HI,
    SEG_SPLIT,
    SEG_REVERSED,
    SEG_STALE,
    SEG_NOISE
  } seg_kind_e;

  typedef struct packed {
    status_e         status;
    logic [RL_W-1:0] left;
    logic            done;
  } reply_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i      = OP_NONE;
  logic [DATA_W-1:0] seg_start_i   = '0;
  logic [DATA_W-1:0] seg_end_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [ST_W-1:0]   status_o;
  logic [RL_W-1:0]   ranges_left_o;
  logic              complete_o;

  // shadow copy of the missing-range table
  logic [DATA_W-1:0] gap_lo   [MAX_RANGES];
  logic [DATA_W-1:0] gap_hi   [MAX_RANGES];
  logic              gap_used [MAX_RANGES];
  int                gap_count = 0;

  reply_t     reply_q[$];
  idle_mode_e idle_mode   = IDLE_NONE;
  int         items_sent  = 0;
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         hold_req    = 0;
  int         hold_left   = 0;

  missing_range_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .seg_start_i   (seg_start_i),
    .seg_end_i     (seg_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .ranges_left_o (ranges_left_o),
    .complete_o    (complete_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int send_pct();
    case (idle_mode)
      IDLE_SEND: return 56;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_pct();
    case (idle_mode)
      IDLE_RECV: return 56;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  // applies one transaction to the shadow table and returns the expected reply
  function automatic reply_t track_op(op_e op, logic [DATA_W-1:0] s, logic [DATA_W-1:0] e);
    reply_t            r;
    int                hit;
    int                free_slot;
    int                best;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] f;
    r.status  = ST_OK;
    hit       = -1;
    free_slot = -1;
    best      = -1;
    case (op)
      OP_INIT: begin
        for (int i = 0; i < MAX_RANGES; i++) gap_used[i] = 1'b0;
        gap_lo[0]   = '0;
        gap_hi[0]   = e;
        gap_used[0] = 1'b1;
        gap_count   = 1;
      end
      OP_RECV: begin
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (!gap_used[i]) begin
            if (free_slot < 0) free_slot = i;
          end else if (hit < 0 && s >= gap_lo[i] && s <= gap_hi[i] &&
                       e >= gap_lo[i] && e <= gap_hi[i]) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          b = gap_lo[hit];
          f = gap_hi[hit];
          if (s == b && e == f) begin
            gap_used[hit] = 1'b0;
            gap_count--;
          end else if (s == b && s < f) begin
            gap_lo[hit] = e;
          end else if (e == f && s > b) begin
            gap_hi[hit] = s;
          end else if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            gap_lo[free_slot]   = e;
            gap_hi[free_slot]   = f;
            gap_used[free_slot] = 1'b1;
            gap_hi[hit]         = s;
            gap_count++;
          end
        end
      end
      OP_EXT: begin
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (gap_used[i] && (best < 0 || gap_lo[i] > gap_lo[best])) best = i;
        end
        if (best < 0) r.status = ST_EMPTY;
        else gap_hi[best] = e;
      end
      default: begin
      end
    endcase
    r.left = RL_W'(gap_count);
    r.done = (gap_count == 0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_between(logic [DATA_W-1:0] lo,
                                                     logic [DATA_W-1:0] hi);
    logic [63:0] span;
    logic [63:0] off;
    span = {32'd0, hi} - {32'd0, lo} + 64'd1;
    case ($urandom_range(9))
      0:       off = '0;
      1:       off = span - 64'd1;
      2:       off = 64'($urandom_range(3));
      default: off = {$urandom, $urandom};
    endcase
    off = off % span;
    return lo + off[DATA_W-1:0];
  endfunction

  // segment of the given kind on a live range; random for noise or if none live
  function automatic void make_segment(seg_kind_e kind, output logic [DATA_W-1:0] s,
                                       output logic [DATA_W-1:0] e);
    int                live[$];
    int                k;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] f;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (gap_used[i] && gap_lo[i] <= gap_hi[i]) live.push_back(i);
    end
    if (kind == SEG_NOISE || live.size() == 0) begin
      s = $urandom;
      e = $urandom;
      return;
    end
    k = live[$urandom_range(live.size() - 1)];
    b = gap_lo[k];
    f = gap_hi[k];
    x = pick_between(b, f);
    y = pick_between(b, f);
    case (kind)
      SEG_EXACT: begin
        s = b;
        e = f;
      end
      SEG_TRIM_LO: begin
        s = b;
        e = x;
      end
      SEG_TRIM_HI: begin
        s = x;
        e = f;
      end
      SEG_REVERSED: begin
        s = (x > y) ? x : y;
        e = (x > y) ? y : x;
      end
      SEG_STALE: begin
        s = (b != '0) ? b - 1 : f + 1;
        e = x;
      end
      default: begin
        s = (x < y) ? x : y;
        e = (x < y) ? y : x;
      end
    endcase
  endfunction

  task automatic send_item(op_e op, logic [DATA_W-1:0] s, logic [DATA_W-1:0] e);
    int pct;
    pct = send_pct();
    if (pct != 0) begin
      while ($urandom_range(99) < pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    seg_start_i <= s;
    seg_end_i   <= e;
    do @(posedge clk_i); while (in_stall_o);
    reply_q.push_back(track_op(op, s, e));
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_pct() != 0) && ($urandom_range(99) < recv_pct());
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected transaction: status %0d left %0d complete %0b",
                   status_o, ranges_left_o, complete_o);
        end
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status || ranges_left_o !== want.left ||
            complete_o !== want.done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"mismatch: status exp %0d got %0d, left exp %0d got %0d, ",
                      "complete exp %0b got %0b"},
                     want.status, status_o, want.left, ranges_left_o, want.done, complete_o);
          end
        end
      end
    end
  end

  task automatic test_directed();
    idle_mode = IDLE_NONE;
    send_item(OP_NONE, '0, '0);
    send_item(OP_RECV, 32'd5, 32'd9);
    send_item(OP_EXT, '0, 32'd100);
    send_item(OP_INIT, '0, '0);
    send_item(OP_RECV, '0, '0);
    send_item(OP_INIT, '1, '1);
    send_item(OP_RECV, '0, 32'h10);
    send_item(OP_RECV, 32'hFFFF_FF00, '1);
    send_item(OP_RECV, 32'h1000, 32'h2000);
    send_item(OP_RECV, 32'h1800, 32'h1900);
    send_item(OP_RECV, 32'h3000, 32'h2800);
    send_item(OP_EXT, '0, '1);
    send_item(OP_NONE, '1, '1);
    // two ranges sharing the highest begin
    send_item(OP_INIT, '0, 32'd100);
    send_item(OP_RECV, 32'd50, 32'd40);
    send_item(OP_RECV, '0, 32'd40);
    send_item(OP_EXT, '0, 32'd200);
    send_item(OP_RECV, 32'd40, 32'd200);
    send_item(OP_RECV, 32'd40, 32'd100);
    send_item(OP_EXT, '0, 32'd5);
    send_item(OP_INIT, 32'hA5A5_A5A5, 32'd10);
    send_item(OP_RECV, '0, 32'd10);
    wait_drain();
  endtask

  task automatic test_table_full();
    idle_mode = IDLE_BOTH;
    send_item(OP_INIT, '0, '1);
    for (int k = 1; k <= MAX_RANGES; k++) begin
      send_item(OP_RECV, 32'(k) << 25, (32'(k) << 25) + 32'd16);
    end
    send_item(OP_EXT, '0, 32'hFFFF_FFF0);
    send_item(OP_RECV, (32'd5 << 25) + 32'd16, 32'd6 << 25);
    send_item(OP_RECV, 32'd1 << 31, (32'd1 << 31) + 32'd16);
    send_item(OP_RECV, (32'd1 << 31) + 32'd100, (32'd1 << 31) + 32'd200);
    send_item(OP_RECV, (32'd1 << 25) + 32'd4, (32'd1 << 25) + 32'd8);
    wait_drain();
  endtask

  task automatic test_backpressure();
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] e;
    idle_mode = IDLE_NONE;
    send_item(OP_INIT, '0, '1);
    hold_req = HOLD_CYCLES;
    repeat (12) begin
      make_segment(SEG_SPLIT, s, e);
      send_item(OP_RECV, s, e);
    end
    wait_drain();
  endtask

  task automatic run_transfer(int len, bit split_heavy);
    int                r;
    seg_kind_e         kind;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] size;
    case ($urandom_range(3))
      0:       size = $urandom_range(300);
      1:       size = '1;
      default: size = $urandom;
    endcase
    send_item(OP_INIT, $urandom, size);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_item(OP_NONE, $urandom, $urandom);
      end else if (!split_heavy && r < 5) begin
        send_item(OP_EXT, $urandom, $urandom);
      end else begin
        r = $urandom_range(99);
        if (split_heavy) begin
          kind = (r < 85) ? SEG_SPLIT : (r < 92) ? SEG_TRIM_LO : SEG_EXACT;
        end else if (r < 6) begin
          kind = SEG_NOISE;
        end else if (r < 16) begin
          kind = SEG_EXACT;
        end else if (r < 34) begin
          kind = SEG_TRIM_LO;
        end else if (r < 52) begin
          kind = SEG_TRIM_HI;
        end else if (r < 84) begin
          kind = SEG_SPLIT;
        end else if (r < 92) begin
          kind = SEG_REVERSED;
        end else begin
          kind = SEG_STALE;
        end
        make_segment(kind, s, e);
        send_item(OP_RECV, s, e);
      end
    end
  endtask

  task automatic test_random();
    int per_phase;
    int stop;
    int len;
    bit heavy;
    per_phase = (TOTAL_ITEMS - items_sent) / 8;
    for (int rep = 0; rep < 2; rep++) begin
      for (int m = 0; m < 4; m++) begin
        idle_mode = idle_mode_e'(m);
        stop = items_sent + per_phase;
        while (items_sent < stop) begin
          heavy = ($urandom_range(3) == 0);
          len   = heavy ? $urandom_range(90, 130) : $urandom_range(10, 60);
          if (len > stop - items_sent - 1) len = stop - items_sent - 1;
          run_transfer(len, heavy);
        end
        wait_drain();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mrt_pkg.sv
rtl/mrt_ram.sv
rtl/mrt_scan.sv
rtl/missing_range_tracker.sv
tb/testbench.sv
